FILE: rtl/tkh_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the top-K weighted score heap.
// Depends on nothing; tkh_score and the top level import it.
package tkh_pkg;

  localparam int HEAP_DEPTH = 16;
  localparam int IDX_W      = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int CHW        = CNT_W + 1;
  localparam int ID_W       = 16;
  localparam int CNT_IN_W   = 32;
  localparam int SCORE_W    = 38;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] score;
  } entry_t;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_PEEK   = 2'd1,
    MODE_DUMP   = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_ADDED    = 3'd1,
    ST_REPLACED = 3'd2,
    ST_DROPPED  = 3'd3,
    ST_PEEK     = 3'd4,
    ST_DUMP     = 3'd5,
    ST_EMPTY    = 3'd6
  } status_e;

endpackage

FILE: rtl/tkh_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module tkh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/tkh_score.sv
`timescale 1ns / 1ps
// Weighted score unit: one shared adder accumulates the weighted counts.
// Depends on tkh_pkg.
module tkh_score (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [tkh_pkg::CNT_IN_W-1:0]    total_i,
  input  logic [tkh_pkg::CNT_IN_W-1:0]    sqli_i,
  input  logic [tkh_pkg::CNT_IN_W-1:0]    client_i,
  input  logic [tkh_pkg::CNT_IN_W-1:0]    server_i,
  output logic                            done_o,
  output logic [tkh_pkg::SCORE_W-1:0]     score_o
);
  import tkh_pkg::*;

  logic [1:0]          step_q;
  logic                done_q;
  logic [SCORE_W-1:0]  acc_q;
  logic [CNT_IN_W-1:0] sqli_q, client_q, server_q;
  logic [SCORE_W-1:0]  term;

  // One weighted term is added per cycle.
  always_comb begin
    case (step_q)
      2'd1:    term = SCORE_W'(sqli_q) * SCORE_W'(50);
      2'd2:    term = SCORE_W'(client_q) * SCORE_W'(3);
      2'd3:    term = SCORE_W'(server_q) * SCORE_W'(5);
      default: term = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 2'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        step_q <= 2'd1;
      end else if (step_q != 2'd0) begin
        step_q <= step_q + 2'd1;
        done_q <= (step_q == 2'd3);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q    <= SCORE_W'(total_i);
      sqli_q   <= sqli_i;
      client_q <= client_i;
      server_q <= server_i;
    end else if (step_q != 2'd0) begin
      acc_q <= acc_q + term;
    end
  end

  assign done_o  = done_q;
  assign score_o = acc_q;

endmodule

FILE: rtl/top_k_weighted_score_heap.sv
`timescale 1ns / 1ps
// Top level of the top-K weighted score heap: sequencer, heap memories.
// Depends on tkh_pkg, tkh_ram and tkh_score.

// The block keeps the HEAP_DEPTH (K) highest-scoring records in a binary
// min-heap and handles one transaction at a time: a transaction is taken
// when start is high while busy is low, and busy falls in the cycle its last
// result appears (an empty peek or dump answers without raising busy).
// Results appear for exactly one cycle each, marked by result_valid_o, and
// the receiver cannot stall them, so it must take every result in the cycle
// it appears. An insert scores the record and searches the heap for its id,
// then adds, updates, replaces or drops it, letting the entry climb or sink.
// A peek reads the root. A dump copies the heap into a working copy, takes
// out each minimum with a sift down, then streams one result per cycle.
// Every step goes through the single read port of the heap memories, and
// every sift step through the one shared score comparator. No clearing pass
// is needed after reset.
module top_k_weighted_score_heap (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   mode_i,
  input  logic [tkh_pkg::ID_W-1:0]     record_id_i,
  input  logic [tkh_pkg::CNT_IN_W-1:0] req_count_i,
  input  logic [tkh_pkg::CNT_IN_W-1:0] inj_hits_i,
  input  logic [tkh_pkg::CNT_IN_W-1:0] client_errors_i,
  input  logic [tkh_pkg::CNT_IN_W-1:0] server_errors_i,
  output logic                         result_valid_o,
  output logic [2:0]                   status_o,
  output logic [tkh_pkg::ID_W-1:0]     out_id_o,
  output logic [tkh_pkg::SCORE_W-1:0]  out_score_o,
  output logic                         last_o
);
  import tkh_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SCORE, S_SRCH, S_SRCH_CMP, S_NEW, S_ROOT,
    S_UP, S_UP_CMP, S_UP_END,
    S_DN, S_DN_L, S_DN_R, S_DN_MV, S_DN_END,
    S_PEEK, S_CPY, S_CPY_WR, S_EX, S_EX_TOP, S_EX_LAST, S_OUT, S_OUT_EM
  } state_e;

  state_e             state_q;
  logic [1:0]         mode_q;
  logic [ID_W-1:0]    id_q;
  logic [SCORE_W-1:0] score_q;
  logic [CNT_W-1:0]   cnt_q;      // entries held in the heap
  logic [CNT_W-1:0]   n_q;        // size of the heap being sifted
  logic [CNT_W-1:0]   k_q;        // search, copy and stream counter
  logic [IDX_W-1:0]   idx_q;      // slot of the hole being moved
  logic [IDX_W-1:0]   start_pos_q;
  logic [IDX_W-1:0]   best_idx_q;
  logic               best_self_q;
  logic               sel_work_q; // sifts act on the working copy
  entry_t             cur_q;
  entry_t             best_q;
  status_e            op_status_q;

  logic               res_valid_q;
  status_e            res_status_q;
  logic [ID_W-1:0]    res_id_q;
  logic [SCORE_W-1:0] res_score_q;
  logic               res_last_q;

  logic               score_start;
  logic               score_done;
  logic [SCORE_W-1:0] score_val;

  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;
  logic               heap_we;
  logic               work_we;
  logic               out_we;
  logic [IDX_W-1:0]   out_waddr;
  logic [IDX_W-1:0]   out_raddr;
  entry_t             heap_rd;
  entry_t             work_rd;
  entry_t             out_rd;
  entry_t             mem_rd;

  logic [SCORE_W-1:0] cmp_a;
  logic [SCORE_W-1:0] cmp_b;
  logic               lt;

  logic [IDX_W-1:0]   idx_m1;
  logic [IDX_W-1:0]   parent;
  logic [CHW-1:0]     l_idx;
  logic [CHW-1:0]     r_idx;
  logic [CHW-1:0]     n_ext;

  assign score_start = start && !busy && (mode_i == MODE_INSERT);

  tkh_score u_score (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (score_start),
    .total_i  (req_count_i),
    .sqli_i   (inj_hits_i),
    .client_i (client_errors_i),
    .server_i (server_errors_i),
    .done_o   (score_done),
    .score_o  (score_val)
  );

  // Heap index arithmetic: parent of the hole and its two children.
  assign idx_m1 = idx_q - IDX_W'(1);
  assign parent = idx_m1 >> 1;
  assign l_idx  = (CHW'(idx_q) << 1) | CHW'(1);
  assign r_idx  = l_idx + CHW'(1);
  assign n_ext  = CHW'(n_q);

  assign mem_rd = sel_work_q ? work_rd : heap_rd;

  // The one score comparator shared by every sift and root step: cmp_a < cmp_b.
  assign lt = (cmp_a < cmp_b);

  always_comb begin
    rd_addr   = idx_q;
    wr_en     = 1'b0;
    wr_addr   = idx_q;
    wr_data   = cur_q;
    out_we    = 1'b0;
    out_waddr = IDX_W'(n_q - CNT_W'(1));
    out_raddr = k_q[IDX_W-1:0];
    cmp_a     = mem_rd.score;
    cmp_b     = cur_q.score;
    case (state_q)
      S_IDLE: begin
        rd_addr = '0;
      end
      S_SRCH: begin
        rd_addr = k_q[IDX_W-1:0];
      end
      S_NEW: begin
        rd_addr = '0;
      end
      S_ROOT: begin
        cmp_b = score_q;
      end
      S_UP: begin
        if (idx_q == '0) begin
          wr_en = 1'b1;
        end else begin
          rd_addr = parent;
        end
      end
      S_UP_CMP: begin
        // The new or updated entry climbs while its parent scores strictly higher.
        cmp_a   = cur_q.score;
        cmp_b   = mem_rd.score;
        wr_en   = 1'b1;
        wr_data = lt ? mem_rd : cur_q;
      end
      S_DN: begin
        if (l_idx >= n_ext) begin
          wr_en = 1'b1;
        end else begin
          rd_addr = l_idx[IDX_W-1:0];
        end
      end
      S_DN_L: begin
        if (r_idx < n_ext) begin
          rd_addr = r_idx[IDX_W-1:0];
        end
      end
      S_DN_R: begin
        cmp_b = best_q.score;
      end
      S_DN_MV: begin
        wr_en   = 1'b1;
        wr_data = best_self_q ? cur_q : best_q;
      end
      S_CPY: begin
        rd_addr = k_q[IDX_W-1:0];
      end
      S_CPY_WR: begin
        wr_en   = 1'b1;
        wr_addr = k_q[IDX_W-1:0];
        wr_data = mem_rd;
      end
      S_EX: begin
        rd_addr = '0;
      end
      S_EX_TOP: begin
        out_we  = 1'b1;
        rd_addr = IDX_W'(n_q - CNT_W'(1));
      end
      default: begin
      end
    endcase
  end

  // The copy sweep reads the live heap and fills the working copy.
  assign heap_we = wr_en && !sel_work_q && (state_q != S_CPY_WR);
  assign work_we = wr_en && (sel_work_q || (state_q == S_CPY_WR));

  tkh_ram #(.WIDTH($bits(entry_t)), .DEPTH(HEAP_DEPTH)) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (heap_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (heap_rd)
  );

  tkh_ram #(.WIDTH($bits(entry_t)), .DEPTH(HEAP_DEPTH)) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (work_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (work_rd)
  );

  // Extracted minima land from the top slot down, so streaming from slot
  // zero upward gives descending score order.
  tkh_ram #(.WIDTH($bits(entry_t)), .DEPTH(HEAP_DEPTH)) u_out_ram (
    .clk_i   (clk_i),
    .we_i    (out_we),
    .waddr_i (out_waddr),
    .wdata_i (mem_rd),
    .raddr_i (out_raddr),
    .rdata_o (out_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      sel_work_q   <= 1'b0;
      res_valid_q  <= 1'b0;
      mode_q       <= '0;
      id_q         <= '0;
      score_q      <= '0;
      n_q          <= '0;
      k_q          <= '0;
      idx_q        <= '0;
      start_pos_q  <= '0;
      best_idx_q   <= '0;
      best_self_q  <= 1'b0;
      cur_q        <= '0;
      best_q       <= '0;
      op_status_q  <= ST_UPDATED;
      res_status_q <= ST_UPDATED;
      res_id_q     <= '0;
      res_score_q  <= '0;
      res_last_q   <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            mode_q <= mode_i;
            id_q   <= record_id_i;
            case (mode_i)
              MODE_INSERT: begin
                state_q <= S_SCORE;
              end
              MODE_PEEK, MODE_DUMP: begin
                if (cnt_q == '0) begin
                  res_valid_q  <= 1'b1;
                  res_status_q <= ST_EMPTY;
                  res_id_q     <= '0;
                  res_score_q  <= '0;
                  res_last_q   <= 1'b1;
                end else if (mode_i == MODE_PEEK) begin
                  state_q <= S_PEEK;
                end else begin
                  k_q        <= '0;
                  sel_work_q <= 1'b0;
                  state_q    <= S_CPY;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCORE: begin
          if (score_done) begin
            score_q    <= score_val;
            k_q        <= '0;
            sel_work_q <= 1'b0;
            state_q    <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (k_q == cnt_q) begin
            state_q <= S_NEW;
          end else begin
            state_q <= S_SRCH_CMP;
          end
        end
        S_SRCH_CMP: begin
          if (mem_rd.id == id_q) begin
            cur_q       <= '{id: id_q, score: score_q};
            idx_q       <= k_q[IDX_W-1:0];
            start_pos_q <= k_q[IDX_W-1:0];
            op_status_q <= ST_UPDATED;
            state_q     <= S_UP;
          end else begin
            k_q     <= k_q + CNT_W'(1);
            state_q <= S_SRCH;
          end
        end
        S_NEW: begin
          if (cnt_q < CNT_W'(HEAP_DEPTH)) begin
            cur_q       <= '{id: id_q, score: score_q};
            idx_q       <= cnt_q[IDX_W-1:0];
            op_status_q <= ST_ADDED;
            state_q     <= S_UP;
          end else begin
            state_q <= S_ROOT;
          end
        end
        S_ROOT: begin
          // A full heap takes the record only on a strictly greater score.
          if (lt) begin
            cur_q       <= '{id: id_q, score: score_q};
            idx_q       <= '0;
            n_q         <= cnt_q;
            op_status_q <= ST_REPLACED;
            state_q     <= S_DN;
          end else begin
            res_valid_q  <= 1'b1;
            res_status_q <= ST_DROPPED;
            res_id_q     <= id_q;
            res_score_q  <= score_q;
            res_last_q   <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        S_UP: begin
          if (idx_q == '0) begin
            state_q <= S_UP_END;
          end else begin
            state_q <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (lt) begin
            idx_q   <= parent;
            state_q <= S_UP;
          end else begin
            state_q <= S_UP_END;
          end
        end
        S_UP_END: begin
          // An updated entry that did not climb may still have to sink.
          if ((op_status_q == ST_UPDATED) && (idx_q == start_pos_q)) begin
            n_q     <= cnt_q;
            state_q <= S_DN;
          end else begin
            if (op_status_q == ST_ADDED) begin
              cnt_q <= cnt_q + CNT_W'(1);
            end
            res_valid_q  <= 1'b1;
            res_status_q <= op_status_q;
            res_id_q     <= id_q;
            res_score_q  <= score_q;
            res_last_q   <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        S_DN: begin
          if (l_idx >= n_ext) begin
            state_q <= S_DN_END;
          end else begin
            state_q <= S_DN_L;
          end
        end
        S_DN_L: begin
          if (lt) begin
            best_q      <= mem_rd;
            best_idx_q  <= l_idx[IDX_W-1:0];
            best_self_q <= 1'b0;
          end else begin
            best_q      <= cur_q;
            best_self_q <= 1'b1;
          end
          if (r_idx < n_ext) begin
            state_q <= S_DN_R;
          end else begin
            state_q <= S_DN_MV;
          end
        end
        S_DN_R: begin
          if (lt) begin
            best_q      <= mem_rd;
            best_idx_q  <= r_idx[IDX_W-1:0];
            best_self_q <= 1'b0;
          end
          state_q <= S_DN_MV;
        end
        S_DN_MV: begin
          if (best_self_q) begin
            state_q <= S_DN_END;
          end else begin
            idx_q   <= best_idx_q;
            state_q <= S_DN;
          end
        end
        S_DN_END: begin
          if (mode_q == MODE_DUMP) begin
            state_q <= S_EX;
          end else begin
            res_valid_q  <= 1'b1;
            res_status_q <= op_status_q;
            res_id_q     <= id_q;
            res_score_q  <= score_q;
            res_last_q   <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        S_PEEK: begin
          res_valid_q  <= 1'b1;
          res_status_q <= ST_PEEK;
          res_id_q     <= mem_rd.id;
          res_score_q  <= mem_rd.score;
          res_last_q   <= 1'b1;
          state_q      <= S_IDLE;
        end
        S_CPY: begin
          if (k_q == cnt_q) begin
            n_q        <= cnt_q;
            sel_work_q <= 1'b1;
            state_q    <= S_EX;
          end else begin
            state_q <= S_CPY_WR;
          end
        end
        S_CPY_WR: begin
          k_q     <= k_q + CNT_W'(1);
          state_q <= S_CPY;
        end
        S_EX: begin
          state_q <= S_EX_TOP;
        end
        S_EX_TOP: begin
          // The minimum is parked; the last entry moves to the root.
          n_q <= n_q - CNT_W'(1);
          if (n_q == CNT_W'(1)) begin
            k_q     <= '0;
            state_q <= S_OUT;
          end else begin
            state_q <= S_EX_LAST;
          end
        end
        S_EX_LAST: begin
          cur_q   <= mem_rd;
          idx_q   <= '0;
          state_q <= S_DN;
        end
        S_OUT: begin
          k_q     <= k_q + CNT_W'(1);
          state_q <= S_OUT_EM;
        end
        S_OUT_EM: begin
          res_valid_q  <= 1'b1;
          res_status_q <= ST_DUMP;
          res_id_q     <= out_rd.id;
          res_score_q  <= out_rd.score;
          res_last_q   <= (k_q == cnt_q);
          if (k_q == cnt_q) begin
            sel_work_q <= 1'b0;
            state_q    <= S_IDLE;
          end else begin
            k_q <= k_q + CNT_W'(1);
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign out_id_o       = res_id_q;
  assign out_score_o    = res_score_q;
  assign last_o         = res_last_q;

endmodule
